[rtl/lbps_pkg.sv]
// Package: types, constants and color reorder functions for the bit-plane pixel store.
package lbps_pkg;

  localparam int IDX_W       = 14;
  localparam int COLOR_W     = 32;
  localparam int LEN_W       = 11;
  localparam int ORDER_W     = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int BITCNT_W    = 5;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_ORDER  = 1'd1;

  localparam logic [LEN_W-1:0]   STRIP_LENGTH_RST = 11'd1;
  localparam logic [BITCNT_W-1:0] LAST_BIT_24     = 5'd23;
  localparam logic [BITCNT_W-1:0] LAST_BIT_32     = 5'd31;

  localparam logic [31:0] MASK_HI   = 32'h00FF0000;
  localparam logic [31:0] MASK_MID  = 32'h0000FF00;
  localparam logic [31:0] MASK_LO   = 32'h000000FF;
  localparam logic [31:0] MASK_HM   = 32'h00FFFF00;
  localparam logic [31:0] MASK_ML   = 32'h0000FFFF;
  localparam logic [31:0] MASK_TOP  = 32'hFF000000;
  localparam logic [31:0] MASK_24   = 32'h00FFFFFF;

  typedef enum logic [ORDER_W-1:0] {
    ORD_RGB,
    ORD_RBG,
    ORD_GRB,
    ORD_GBR,
    ORD_GRBW
  } order_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_MOD,
    ST_FIN
  } state_t;

  function automatic logic [31:0] to_wire(input logic [31:0] c, input order_t order);
    logic [31:0] r;
    case (order)
      ORD_RBG:  r = (c & MASK_HI) | ((c << 8) & MASK_MID) | ((c >> 8) & MASK_LO);
      ORD_GRB:  r = ((c << 8) & MASK_HI) | ((c >> 8) & MASK_MID) | (c & MASK_LO);
      ORD_GBR:  r = ((c << 8) & MASK_HM) | ((c >> 16) & MASK_LO);
      ORD_GRBW: r = ((c << 16) & MASK_TOP) | (c & MASK_HI) | ((c << 8) & MASK_MID) |
                    ((c >> 24) & MASK_LO);
      default:  r = c & MASK_24;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] from_wire(input logic [31:0] s, input order_t order);
    logic [31:0] r;
    case (order)
      ORD_RBG:  r = (s & MASK_HI) | ((s << 8) & MASK_MID) | ((s >> 8) & MASK_LO);
      ORD_GRB:  r = ((s << 8) & MASK_HI) | ((s >> 8) & MASK_MID) | (s & MASK_LO);
      ORD_GBR:  r = ((s << 16) & MASK_HI) | ((s >> 8) & MASK_ML);
      ORD_GRBW: r = ((s << 24) & MASK_TOP) | (s & MASK_HI) | ((s >> 16) & MASK_MID) |
                    ((s >> 8) & MASK_LO);
      default:  r = s & MASK_24;
    endcase
    return r;
  endfunction

endpackage

[rtl/lbps_ifs.sv]
// Interfaces: pixel request, result and configuration channels.
interface lbps_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [lbps_pkg::IDX_W-1:0]    led_index;
  logic [lbps_pkg::COLOR_W-1:0]  color;
  modport source (output valid, kind, led_index, color, input ready);
  modport sink   (input valid, kind, led_index, color, output ready);
endinterface

interface lbps_out_if;
  logic                          valid;
  logic                          ready;
  logic [lbps_pkg::COLOR_W-1:0]  read_color;
  logic                          out_of_range;
  modport source (output valid, read_color, out_of_range, input ready);
  modport sink   (input valid, read_color, out_of_range, output ready);
endinterface

interface lbps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lbps_pkg::CFG_INDEX_W-1:0]  index;
  logic [lbps_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/led_bitplane_pixel_store_top.sv]
// Top level: bit-plane pixel store with serial divide and bit-serial read-modify-write.
// Each item is divided by the strip length; then its B color bits, B = 24 (RGB orders)
// or 32 (GRBW), are read in turn, each written back for a write. An out-of-range index
// skips the bit loop. A new item is taken only once the last result is in the output
// register. The divider yields one quotient bit per cycle; the RAM has one port pair.
// Reset (synchronous, active low) sets config to its reset values and then sweeps all
// MAX_LEDS_PER_STRIP * MAX_BITS_PER_LED store words to zero, one per cycle, input held off.
module led_bitplane_pixel_store_top #(
  parameter int NUM_STRIPS         = 16,
  parameter int MAX_LEDS_PER_STRIP = 1024,
  parameter int MAX_BITS_PER_LED   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  lbps_in_if.sink     in_ch,
  lbps_out_if.source  out_ch,
  lbps_cfg_if.sink    cfg_ch
);

  localparam int DEPTH  = MAX_LEDS_PER_STRIP * MAX_BITS_PER_LED;
  localparam int AW     = $clog2(DEPTH);
  localparam int ADDR_W = AW + 1;
  localparam int SW     = (NUM_STRIPS > 1) ? $clog2(NUM_STRIPS) : 1;
  localparam int IW     = lbps_pkg::IDX_W;
  localparam int LW     = lbps_pkg::LEN_W;
  localparam int CW     = lbps_pkg::COLOR_W;
  localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DEPTH - 1);

  lbps_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]                   strip_length_r;
  logic [lbps_pkg::ORDER_W-1:0]    color_order_r;
  logic                            kind_r;
  lbps_pkg::order_t                order_r;
  logic [CW-1:0]                   wire_r;
  logic [CW-1:0]                   acc_r;
  logic [ADDR_W-1:0]               addr_r;
  logic [lbps_pkg::BITCNT_W-1:0]   bit_r;
  logic [SW-1:0]                   lane_r;
  logic                            oor_r;
  logic                            out_valid_r;
  logic [CW-1:0]                   read_color_r;
  logic                            out_of_range_r;

  logic                            in_ready;
  logic                            in_acc;
  logic                            out_acc;
  logic [LW-1:0]                   len_eff;
  lbps_pkg::order_t                order_in;
  logic [CW-1:0]                   wire_in;

  logic                            div_done;
  logic [IW-1:0]                   div_quo;
  logic [LW-1:0]                   div_rem;
  logic                            strip_bad;
  logic [ADDR_W-1:0]               pos_ext;
  logic [ADDR_W-1:0]               base;

  logic                            in_store;
  logic                            last_bit;
  logic                            store_bit;
  logic                            load_out;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [NUM_STRIPS-1:0]           ram_wdata;
  logic [NUM_STRIPS-1:0]           ram_rdata;

  assign in_acc  = in_ch.valid && in_ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_comb begin
    len_eff = strip_length_r;
    if (strip_length_r == '0) begin
      len_eff = LW'(1);
    end else if (32'(strip_length_r) > MAX_LEDS_PER_STRIP) begin
      len_eff = LW'(MAX_LEDS_PER_STRIP);
    end
  end

  always_comb begin
    if (color_order_r > lbps_pkg::ORDER_W'(lbps_pkg::ORD_GRBW)) begin
      order_in = lbps_pkg::ORD_RGB;
    end else begin
      order_in = lbps_pkg::order_t'(color_order_r);
    end
    wire_in = lbps_pkg::to_wire(in_ch.color, order_in);
    if (order_in != lbps_pkg::ORD_GRBW) begin
      wire_in = {wire_in[23:0], 8'h00};
    end
  end

  lbps_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .dividend  (in_ch.led_index),
    .divisor   (len_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign strip_bad = div_quo >= IW'(NUM_STRIPS);
  assign pos_ext   = ADDR_W'(div_rem);
  assign base      = (order_r == lbps_pkg::ORD_GRBW) ? (pos_ext << 5)
                                                     : ((pos_ext << 4) + (pos_ext << 3));

  assign in_store  = addr_r < DEPTH_A;
  assign last_bit  = bit_r == ((order_r == lbps_pkg::ORD_GRBW) ? lbps_pkg::LAST_BIT_32
                                                               : lbps_pkg::LAST_BIT_24);
  assign store_bit = in_store && ram_rdata[lane_r];
  assign load_out  = (state_r == lbps_pkg::ST_FIN) && (!out_valid_r || out_ch.ready);

  lbps_ram #(
    .WIDTH (NUM_STRIPS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbps_pkg::ST_CLEAR: begin
        if (addr_r == LAST_A) begin
          state_nxt = lbps_pkg::ST_IDLE;
        end
      end
      lbps_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = lbps_pkg::ST_DIV;
        end
      end
      lbps_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = strip_bad ? lbps_pkg::ST_FIN : lbps_pkg::ST_RD;
        end
      end
      lbps_pkg::ST_RD:  state_nxt = lbps_pkg::ST_MOD;
      lbps_pkg::ST_MOD: state_nxt = last_bit ? lbps_pkg::ST_FIN : lbps_pkg::ST_RD;
      lbps_pkg::ST_FIN: begin
        if (load_out) begin
          state_nxt = lbps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lbps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_r[AW-1:0];
    ram_wdata = ram_rdata;
    case (state_r)
      lbps_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      lbps_pkg::ST_IDLE: in_ready = 1'b1;
      lbps_pkg::ST_MOD: begin
        ram_we            = (kind_r == lbps_pkg::KIND_WRITE) && in_store;
        ram_wdata[lane_r] = wire_r[CW-1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lbps_pkg::ST_CLEAR;
      addr_r         <= '0;
      strip_length_r <= lbps_pkg::STRIP_LENGTH_RST;
      color_order_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          lbps_pkg::CFG_STRIP_LENGTH: strip_length_r <= cfg_ch.data[LW-1:0];
          lbps_pkg::CFG_COLOR_ORDER:  color_order_r  <= cfg_ch.data[lbps_pkg::ORDER_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        lbps_pkg::ST_CLEAR: addr_r <= addr_r + 1'b1;
        lbps_pkg::ST_DIV: begin
          if (div_done) begin
            addr_r <= base;
          end
        end
        lbps_pkg::ST_MOD: addr_r <= addr_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_ch.kind;
      order_r <= order_in;
      wire_r  <= wire_in;
      acc_r   <= '0;
      bit_r   <= '0;
    end
    if ((state_r == lbps_pkg::ST_DIV) && div_done) begin
      oor_r  <= strip_bad;
      lane_r <= div_quo[SW-1:0];
    end
    if (state_r == lbps_pkg::ST_MOD) begin
      acc_r  <= {acc_r[CW-2:0], store_bit};
      wire_r <= {wire_r[CW-2:0], 1'b0};
      bit_r  <= bit_r + 1'b1;
    end
    if (load_out) begin
      out_of_range_r <= oor_r;
      read_color_r   <= ((kind_r == lbps_pkg::KIND_READ) && !oor_r)
                        ? lbps_pkg::from_wire(acc_r, order_r) : '0;
    end
  end

  assign in_ch.ready         = in_ready;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_color   = read_color_r;
  assign out_ch.out_of_range = out_of_range_r;

endmodule

[rtl/lbps_ram.sv]
// Generic simple dual-port RAM with registered read.
module lbps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lbps_divider.sv]
// Restoring serial divider: LED index by strip length, one quotient bit per cycle.
module lbps_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lbps_pkg::IDX_W-1:0]  dividend,
  input  logic [lbps_pkg::LEN_W-1:0]  divisor,
  output logic                        done,
  output logic [lbps_pkg::IDX_W-1:0]  quotient,
  output logic [lbps_pkg::LEN_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(lbps_pkg::IDX_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(lbps_pkg::IDX_W - 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [lbps_pkg::IDX_W-1:0]  quo_r;
  logic [lbps_pkg::LEN_W-1:0]  rem_r;
  logic [lbps_pkg::LEN_W-1:0]  div_r;
  logic [lbps_pkg::LEN_W:0]    trial;
  logic                        fits;

  assign trial = {rem_r, quo_r[lbps_pkg::IDX_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[lbps_pkg::IDX_W-2:0], fits};
      rem_r <= fits ? lbps_pkg::LEN_W'(trial - {1'b0, div_r})
                    : trial[lbps_pkg::LEN_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/lbps_checker.sv]
// Checker: port-level properties of the bit-plane pixel store, bound to the top level.
module lbps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_color,
  input logic        out_of_range
);

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_color) && $stable(out_of_range))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> read_color == 32'h0)
    else $error("out-of-range result carries a color");

  assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind led_bitplane_pixel_store_top lbps_checker u_lbps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .read_color   (out_ch.read_color),
  .out_of_range (out_ch.out_of_range)
);
